/* rtl/core/tlbat_pkg.sv */
// ---------------------------------------------------------------------------
// TLB address translator package
// Shared sizes, request and result types, and the TLB entry record.
// ---------------------------------------------------------------------------
package tlbat_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_BITS   = 8;
  localparam int TABLE_DEPTH = 1 << PAGE_BITS;
  localparam int FRAME_BITS  = 8;
  localparam int COUNT_BITS  = 32;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_TABLE_WR  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] logical_address;
    logic [7:0]  table_page;
    logic [7:0]  table_frame;
  } in_item_t;

  typedef struct packed {
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic [7:0]  page_number;
    logic [7:0]  page_offset;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  tag;
    logic [FRAME_BITS-1:0] frame;
  } tlb_entry_t;

endpackage

/* rtl/core/tlbat_cell.sv */
// ---------------------------------------------------------------------------
// TLB cell
// One TLB entry. Compares its tag with the looked-up page and, on a fill,
// takes the entry of its upstream neighbor.
// ---------------------------------------------------------------------------
module tlbat_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  tlbat_pkg::tlb_entry_t           entry_in,
  input  logic [tlbat_pkg::PAGE_BITS-1:0] lookup_page,
  output tlbat_pkg::tlb_entry_t           entry_out,
  output logic                            match
);
  import tlbat_pkg::*;

  logic                  valid_r;
  logic [PAGE_BITS-1:0]  tag_r;
  logic [FRAME_BITS-1:0] frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag_r   <= entry_in.tag;
      frame_r <= entry_in.frame;
    end
  end

  assign entry_out = '{valid: valid_r, tag: tag_r, frame: frame_r};
  assign match     = valid_r && (tag_r == lookup_page);

endmodule

/* rtl/core/tlb_address_translator.sv */
// ---------------------------------------------------------------------------
// TLB address translator
// Translates logical addresses through a 16-entry fully associative TLB
// built as a shifting row of cells, backed by a 256-entry frame table.
// ---------------------------------------------------------------------------
//   Channel   Ports                         Carries
//   input     in_valid, in_stall, in_data   translate or frame-table write
//   output    out_valid, out_stall, out_data translation result
//
// In a translate request, the TLB compare and the registered frame-table
// read happen in the accept cycle; the result and any TLB fill follow in
// S_RESOLVE once the output is free. A frame-table write gives no result.
// Reset invalidates all TLB entries and clears both counters; the frame
// table is not cleared. A stalled result holds its slot; one more request
// can be accepted and looked up behind it.
module tlb_address_translator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlbat_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlbat_pkg::out_item_t out_data
);
  import tlbat_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  state_t state_r;

  logic [FRAME_BITS-1:0] frame_mem [TABLE_DEPTH];
  logic [FRAME_BITS-1:0] mem_rd_r;

  tlb_entry_t             chain [TLB_ENTRIES+1];
  logic [TLB_ENTRIES-1:0] match;

  logic [PAGE_BITS-1:0]   lookup_page;
  logic [FRAME_BITS-1:0]  tlb_frame;
  logic                   in_accept;
  logic                   out_free;
  logic                   resolve;
  logic                   shift_en;

  logic                   hit_r;
  logic [FRAME_BITS-1:0]  tlb_frame_r;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;

  logic [COUNT_BITS-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_BITS-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [FRAME_BITS-1:0]  frame_sel;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  assign in_stall    = (state_r != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign resolve     = (state_r == S_RESOLVE) && out_free;
  assign shift_en    = resolve && !hit_r;
  assign lookup_page = in_data.logical_address[OFFSET_BITS +: PAGE_BITS];

  // New entries enter at the head; the oldest falls off the tail.
  assign chain[0] = '{valid: 1'b1, tag: page_r, frame: mem_rd_r};

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    tlbat_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .entry_in    (chain[g]),
      .lookup_page (lookup_page),
      .entry_out   (chain[g+1]),
      .match       (match[g])
    );
  end

  // Valid tags are unique, so an OR across the matching cells selects one.
  always_comb begin
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_frame = tlb_frame | ({FRAME_BITS{match[i]}} & chain[i+1].frame);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (in_data.opcode == OP_TABLE_WR) begin
        frame_mem[in_data.table_page[PAGE_BITS-1:0]] <= in_data.table_frame;
      end
      mem_rd_r <= frame_mem[lookup_page];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hit_r       <= |match;
      tlb_frame_r <= tlb_frame;
      page_r      <= lookup_page;
      offset_r    <= in_data.logical_address[OFFSET_BITS-1:0];
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit_r) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    frame_sel = hit_r ? tlb_frame_r : mem_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && in_data.opcode == OP_TRANSLATE) state_r <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (resolve) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (resolve) begin
        out_valid_r                 <= 1'b1;
        hit_cnt_r                   <= hit_cnt_nxt;
        miss_cnt_r                  <= miss_cnt_nxt;
        out_data_r.physical_address <= 16'({frame_sel, offset_r});
        out_data_r.tlb_hit          <= hit_r;
        out_data_r.page_number      <= 8'(page_r);
        out_data_r.page_offset      <= 8'(offset_r);
        out_data_r.hit_total        <= hit_cnt_nxt;
        out_data_r.miss_total       <= miss_cnt_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(match) <= 1)
    else $error("more than one TLB cell matches the page");

  a_fill_head: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> chain[1].valid && chain[1].tag == $past(page_r))
    else $error("missed page not placed at the head of the TLB");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (resolve && hit_r) |=> (hit_cnt_r == $past(hit_cnt_r) + 1'b1) ||
                           (hit_cnt_r == $past(hit_cnt_r) && hit_cnt_r == '1))
    else $error("hit counter did not advance on a hit");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    (resolve && !hit_r) |=> (miss_cnt_r == $past(miss_cnt_r) + 1'b1) ||
                            (miss_cnt_r == $past(miss_cnt_r) && miss_cnt_r == '1))
    else $error("miss counter did not advance on a miss");

endmodule
